// ===== rtl/irsoa_pkg.sv =====
package irsoa_pkg;

    // Item kinds
    localparam logic [1:0] KIND_SCAN   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_SONAR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MOTORS_ENABLED  = 2'd0;
    localparam logic [1:0] REG_IR_THRESHOLD    = 2'd1;
    localparam logic [1:0] REG_SONAR_THRESHOLD = 2'd2;

    localparam int unsigned NUM_IR = 7;

    // IR channel numbers
    localparam logic [2:0] CH_LONG_RIGHT  = 3'd0;
    localparam logic [2:0] CH_FRONT       = 3'd1;
    localparam logic [2:0] CH_LONG_LEFT   = 3'd2;
    localparam logic [2:0] CH_FRONT_RIGHT = 3'd4;
    localparam logic [2:0] CH_FRONT_LEFT  = 3'd5;
    localparam logic [2:0] CH_LAST        = 3'd6;

    localparam logic signed [7:0] FULL_DRIVE = 8'sd127;
    localparam logic signed [7:0] FULL_BACK  = -8'sd127;

    // Register reset values
    localparam logic        MOTORS_ENABLED_RST  = 1'b1;
    localparam logic [7:0]  IR_THRESHOLD_RST    = 8'd100;
    localparam logic [23:0] SONAR_THRESHOLD_RST = 24'd1750000;

    // Reciprocals for divide by ten
    localparam logic [15:0] RECIP10_IR    = 16'd52429;      // 2^19 / 10, rounded up
    localparam logic [27:0] RECIP10_SONAR = 28'd214748365;  // 2^31 / 10, rounded up

    typedef logic [7:0] ir_level_t;
    typedef ir_level_t ir_array_t [NUM_IR];

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ir_lr;
        logic [7:0]  ir_front_center;
        logic [7:0]  ir_ll;
        logic [7:0]  ir_side_right;
        logic [7:0]  ir_fr;
        logic [7:0]  ir_fl;
        logic [7:0]  ir_side_left;
        logic [7:0]  single_sample;
        logic [23:0] sonar_echo;
    } item_t;

    // Decision handed from the decide logic to the state and result registers
    typedef struct packed {
        logic              emit;
        logic              drive_valid;
        logic signed [7:0] left_drive;
        logic signed [7:0] right_drive;
        logic              panic_next;
        logic [2:0]        channel_next;
        logic              offset_we;
        logic signed [3:0] offset_next;
    } decision_t;

    // (x + 9*old) / 10 for an 8-bit channel
    function automatic logic [7:0] smooth_ir(input logic [7:0] x, input logic [7:0] old);
        logic [11:0] sum;
        logic [27:0] prod;
        sum  = {4'd0, x} + {1'b0, old, 3'd0} + {4'd0, old};
        prod = {16'd0, sum} * {12'd0, RECIP10_IR};
        return prod[26:19];
    endfunction

    // (x + 9*old) / 10 for the 24-bit sonar level
    function automatic logic [23:0] smooth_sonar(input logic [23:0] x,
                                                 input logic [23:0] old);
        logic [27:0] sum;
        logic [55:0] prod;
        sum  = {4'd0, x} + {1'b0, old, 3'd0} + {4'd0, old};
        prod = {28'd0, sum} * {28'd0, RECIP10_SONAR};
        return prod[54:31];
    endfunction

endpackage

// ===== rtl/irsoa_if.sv =====
interface irsoa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  ir_lr;
    logic [7:0]  ir_front_center;
    logic [7:0]  ir_ll;
    logic [7:0]  ir_side_right;
    logic [7:0]  ir_fr;
    logic [7:0]  ir_fl;
    logic [7:0]  ir_side_left;
    logic [7:0]  single_sample;
    logic [23:0] sonar_echo;

    modport source
    (
        output valid, kind, ir_lr, ir_front_center, ir_ll, ir_side_right,
               ir_fr, ir_fl, ir_side_left, single_sample, sonar_echo,
        input  ready
    );
    modport sink
    (
        input  valid, kind, ir_lr, ir_front_center, ir_ll, ir_side_right,
               ir_fr, ir_fl, ir_side_left, single_sample, sonar_echo,
        output ready
    );
endinterface

interface irsoa_out_if;
    logic              valid;
    logic              ready;
    logic              drive_valid;
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              panic_active;
    logic [2:0]        watched_channel;
    logic signed [3:0] steer_offset;

    modport source
    (
        output valid, drive_valid, left_drive, right_drive, panic_active,
               watched_channel, steer_offset,
        input  ready
    );
    modport sink
    (
        input  valid, drive_valid, left_drive, right_drive, panic_active,
               watched_channel, steer_offset,
        output ready
    );
endinterface

// ===== rtl/irsoa_decide.sv =====
module irsoa_decide
    import irsoa_pkg::*;
(
    input  logic [1:0]  kind,
    input  ir_array_t   ir_new,
    input  logic [2:0]  watch_idx,
    input  logic [23:0] sonar_level,
    input  logic        panic_mode,
    input  logic        motors_enabled,
    input  logic [7:0]  ir_threshold,
    input  logic [23:0] sonar_threshold,
    output decision_t   dec
);

    // Truncating quotient magnitude of |d| / 100 and |d| / 50, sign restored
    function automatic logic signed [3:0] div100(input logic signed [8:0] d);
        logic [7:0] mag;
        logic [3:0] q;
        mag = d[8] ? 8'(-d) : d[7:0];
        q   = (mag >= 8'd200) ? 4'd2 : ((mag >= 8'd100) ? 4'd1 : 4'd0);
        return d[8] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [3:0] div50(input logic signed [8:0] d);
        logic [7:0] mag;
        logic [3:0] q;
        mag = d[8] ? 8'(-d) : d[7:0];
        q   = {3'd0, mag >= 8'd50} + {3'd0, mag >= 8'd100} + {3'd0, mag >= 8'd150}
            + {3'd0, mag >= 8'd200} + {3'd0, mag >= 8'd250};
        return d[8] ? -$signed(q) : $signed(q);
    endfunction

    logic signed [8:0] front_diff;
    logic signed [8:0] long_diff;
    logic signed [3:0] offset;
    logic              front_hit;
    logic              left_hit;
    logic              right_hit;
    logic              left_wins;
    logic              clear;

    // Steering offset from the freshly smoothed scan
    assign front_diff = $signed({1'b0, ir_new[CH_FRONT_LEFT]})
                      - $signed({1'b0, ir_new[CH_FRONT_RIGHT]});
    assign long_diff  = $signed({1'b0, ir_new[CH_LONG_LEFT]})
                      - $signed({1'b0, ir_new[CH_LONG_RIGHT]});
    assign offset     = div100(front_diff) + div50(long_diff);

    // Obstacle tests
    assign front_hit = (ir_new[CH_FRONT] > ir_threshold) || (sonar_level > sonar_threshold);
    assign left_hit  = ir_new[CH_FRONT_LEFT] > ir_threshold;
    assign right_hit = ir_new[CH_FRONT_RIGHT] > ir_threshold;
    assign left_wins = ir_new[CH_FRONT_LEFT] > ir_new[CH_FRONT_RIGHT];
    assign clear     = (ir_new[watch_idx] < ir_threshold) && (sonar_level < sonar_threshold);

    always_comb
    begin
        dec              = '0;
        dec.panic_next   = panic_mode;
        dec.channel_next = watch_idx;
        dec.offset_next  = offset;
        case (kind)
            KIND_SCAN:
            begin
                if (!panic_mode)
                begin
                    dec.emit        = 1'b1;
                    dec.drive_valid = 1'b1;
                    dec.offset_we   = 1'b1;
                    if (offset > 4'sd0)
                    begin
                        dec.left_drive  = FULL_DRIVE;
                        dec.right_drive = FULL_DRIVE - 8'(offset);
                    end
                    else
                    begin
                        dec.left_drive  = FULL_DRIVE + 8'(offset);
                        dec.right_drive = FULL_DRIVE;
                    end
                    if (front_hit)
                    begin
                        dec.panic_next   = 1'b1;
                        dec.channel_next = CH_FRONT;
                        if (motors_enabled)
                        begin
                            dec.left_drive  = left_wins ? FULL_BACK : FULL_DRIVE;
                            dec.right_drive = left_wins ? FULL_DRIVE : FULL_BACK;
                        end
                    end
                    else if (left_hit)
                    begin
                        dec.panic_next   = 1'b1;
                        dec.channel_next = CH_FRONT_LEFT;
                        if (motors_enabled)
                        begin
                            dec.left_drive  = FULL_BACK;
                            dec.right_drive = FULL_DRIVE;
                        end
                    end
                    else if (right_hit)
                    begin
                        dec.panic_next   = 1'b1;
                        dec.channel_next = CH_FRONT_RIGHT;
                        if (motors_enabled)
                        begin
                            dec.left_drive  = FULL_DRIVE;
                            dec.right_drive = FULL_BACK;
                        end
                    end
                end
            end
            KIND_SINGLE:
            begin
                if (panic_mode)
                begin
                    dec.emit = 1'b1;
                    if (clear)
                    begin
                        dec.panic_next  = 1'b0;
                        dec.drive_valid = motors_enabled;
                        if (motors_enabled)
                        begin
                            dec.left_drive  = FULL_DRIVE;
                            dec.right_drive = FULL_DRIVE;
                        end
                    end
                end
            end
            KIND_SONAR:
            begin
                dec.emit = 1'b1;
            end
            default:
            begin
                dec.emit = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/ir_sonar_obstacle_avoider_unit.sv =====
// An accepted item passes the input register, then the result register, one item per cycle
// unless out_ch.ready stalls; smoothing, offset and panic decisions finish in one pass.
// Items that cause no result (kind mismatched to the mode) load no result register.
// Reset (rst_n low, asynchronous): smoothed levels, panic state and offset clear to zero,
// registers return to motors enabled, IR threshold 100 and sonar threshold 1750000.
module ir_sonar_obstacle_avoider_unit
    import irsoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    irsoa_in_if.sink    in_ch,
    irsoa_out_if.source out_ch
);

    logic              motors_enabled_reg;
    logic [7:0]        ir_threshold_reg;
    logic [23:0]       sonar_threshold_reg;

    logic              in_valid_reg;
    item_t             item_reg;

    ir_array_t         ir_reg;
    ir_array_t         ir_next;
    logic [7:0]        scan_x [NUM_IR];
    logic [23:0]       sonar_reg;
    logic [23:0]       sonar_next;
    logic              panic_reg;
    logic [2:0]        channel_reg;
    logic signed [3:0] offset_reg;
    logic [2:0]        watch_idx;

    logic              out_valid_reg;
    logic              drive_valid_reg;
    logic signed [7:0] left_reg;
    logic signed [7:0] right_reg;

    logic              advance;
    decision_t         dec;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motors_enabled_reg  <= MOTORS_ENABLED_RST;
            ir_threshold_reg    <= IR_THRESHOLD_RST;
            sonar_threshold_reg <= SONAR_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MOTORS_ENABLED:  motors_enabled_reg  <= cfg_data[0];
                REG_IR_THRESHOLD:    ir_threshold_reg    <= cfg_data[7:0];
                REG_SONAR_THRESHOLD: sonar_threshold_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Advance the input register whenever the result register can take the item
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ch.ready)
            in_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_reg.kind            <= in_ch.kind;
            item_reg.ir_lr           <= in_ch.ir_lr;
            item_reg.ir_front_center <= in_ch.ir_front_center;
            item_reg.ir_ll           <= in_ch.ir_ll;
            item_reg.ir_side_right   <= in_ch.ir_side_right;
            item_reg.ir_fr           <= in_ch.ir_fr;
            item_reg.ir_fl           <= in_ch.ir_fl;
            item_reg.ir_side_left    <= in_ch.ir_side_left;
            item_reg.single_sample   <= in_ch.single_sample;
            item_reg.sonar_echo      <= in_ch.sonar_echo;
        end
    end

    // Smooth every channel; a single sample feeds all filters, only the watched one stores
    assign watch_idx = (channel_reg > CH_LAST) ? CH_FRONT : channel_reg;
    assign scan_x[0] = item_reg.ir_lr;
    assign scan_x[1] = item_reg.ir_front_center;
    assign scan_x[2] = item_reg.ir_ll;
    assign scan_x[3] = item_reg.ir_side_right;
    assign scan_x[4] = item_reg.ir_fr;
    assign scan_x[5] = item_reg.ir_fl;
    assign scan_x[6] = item_reg.ir_side_left;

    always_comb
    begin
        for (int i = 0; i < NUM_IR; i++)
        begin
            ir_next[i] = smooth_ir((item_reg.kind == KIND_SCAN) ? scan_x[i]
                                                                : item_reg.single_sample,
                                   ir_reg[i]);
        end
    end

    assign sonar_next = smooth_sonar(item_reg.sonar_echo, sonar_reg);

    irsoa_decide u_decide
    (
        .kind            (item_reg.kind),
        .ir_new          (ir_next),
        .watch_idx       (watch_idx),
        .sonar_level     (sonar_reg),
        .panic_mode      (panic_reg),
        .motors_enabled  (motors_enabled_reg),
        .ir_threshold    (ir_threshold_reg),
        .sonar_threshold (sonar_threshold_reg),
        .dec             (dec)
    );

    // Update state when an item that gives a result leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_IR; i++)
                ir_reg[i] <= '0;
            sonar_reg   <= '0;
            panic_reg   <= 1'b0;
            channel_reg <= '0;
            offset_reg  <= '0;
        end
        else if (advance && dec.emit)
        begin
            for (int i = 0; i < NUM_IR; i++)
            begin
                if (item_reg.kind == KIND_SCAN
                    || (item_reg.kind == KIND_SINGLE && watch_idx == 3'(i)))
                    ir_reg[i] <= ir_next[i];
            end
            if (item_reg.kind == KIND_SONAR)
                sonar_reg <= sonar_next;
            panic_reg   <= dec.panic_next;
            channel_reg <= dec.channel_next;
            if (dec.offset_we)
                offset_reg <= dec.offset_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && dec.emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec.emit)
        begin
            drive_valid_reg <= dec.drive_valid;
            left_reg        <= dec.left_drive;
            right_reg       <= dec.right_drive;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.drive_valid     = drive_valid_reg;
    assign out_ch.left_drive      = left_reg;
    assign out_ch.right_drive     = right_reg;
    assign out_ch.panic_active    = panic_reg;
    assign out_ch.watched_channel = channel_reg;
    assign out_ch.steer_offset    = offset_reg;

`ifndef SYNTHESIS
    // Panic always watches one of the three front channels
    assert property (@(posedge clk) disable iff (!rst_n)
        panic_reg |-> (channel_reg == CH_FRONT || channel_reg == CH_FRONT_LEFT
                       || channel_reg == CH_FRONT_RIGHT))
        else $error("panic watches a non-front channel");

    // A result without a command carries zero drive
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !drive_valid_reg) |-> (left_reg == 8'sd0 && right_reg == 8'sd0))
        else $error("drive nonzero without command");

    // Offset stays within plus or minus seven
    assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg != -4'sd8)
        else $error("steering offset out of range");

    // Input stalls only while an item sits in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with room downstream");
`endif

endmodule
